[rtl/cht_pkg.sv]
// ----------------------------------------------------------------------------
// cht_pkg
// Types, codes and defaults shared by the connection hash table modules.
// ----------------------------------------------------------------------------
package cht_pkg;

   localparam int NODES_DEFAULT   = 1024;
   localparam int BUCKETS_DEFAULT = 256;

   // key remainder is built this many key bits per cycle
   localparam int DIV_BITS  = 4;
   localparam int DIV_STEPS = 64 / DIV_BITS;

   localparam logic [2:0] OP_GET   = 3'd0;
   localparam logic [2:0] OP_ADD   = 3'd1;
   localparam logic [2:0] OP_DEL   = 3'd2;
   localparam logic [2:0] OP_TOUT  = 3'd3;
   localparam logic [2:0] OP_CLEAR = 3'd4;

   localparam logic [1:0] CSR_BUCKET_COUNT = 2'd0;
   localparam logic [1:0] CSR_TIMEOUT      = 2'd1;
   localparam logic [1:0] CSR_CHAIN_LIMIT  = 2'd2;

   localparam logic [8:0]  BUCKET_COUNT_RESET = 9'd256;
   localparam logic [31:0] TIMEOUT_RESET      = 32'd60;
   localparam logic [10:0] CHAIN_LIMIT_RESET  = 11'd100;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_ZERO_KEY  = 3'd1,
      STATUS_MISMATCH  = 3'd2,
      STATUS_DUPLICATE = 3'd3,
      STATUS_CHAIN     = 3'd4,
      STATUS_POOL      = 3'd5,
      STATUS_NOT_FOUND = 3'd6
   } status_type;

   typedef struct packed {
      logic [2:0]  operation;
      logic [63:0] conn_key;
      logic [31:0] owner_id;
      logic [30:0] sock_number;
      logic [31:0] now_seconds;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        timed_out;
      logic [31:0] entry_time;
      logic [10:0] used_entries;
      logic [10:0] free_entries;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       div_step;
      logic       head_rd;
      logic       walk_init;
      logic       node_rd;
      logic       walk_adv;
      logic       time_wr;
      logic       unlink;
      logic       free_push;
      logic       alloc_rd;
      logic       alloc_commit;
      logic       clear_all;
      logic       set_status;
      status_type res_status;
      logic       time_now;
      logic       time_stored;
      logic       tout_one;
      logic       tout_calc;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       key_zero;
      logic       key_mismatch;
      logic       div_last;
      logic       cur_nil;
      logic       key_match;
      logic       chain_over;
      logic       pool_full;
      logic       rsp_busy;
   } stat_type;

endpackage

[rtl/cht_ctrl.sv]
// ----------------------------------------------------------------------------
// cht_ctrl
// Sequencer for the connection table: decode, remainder, chain walk, update.
// ----------------------------------------------------------------------------
module cht_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cht_pkg::stat_type stat,
   output cht_pkg::cmd_type  cmd
);
   import cht_pkg::*;

   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_CHECK  = 13'b0000000000010,
      S_DIV    = 13'b0000000000100,
      S_HEAD   = 13'b0000000001000,
      S_INIT   = 13'b0000000010000,
      S_READ   = 13'b0000000100000,
      S_CMP    = 13'b0000001000000,
      S_UNLINK = 13'b0000010000000,
      S_FREE   = 13'b0000100000000,
      S_ALLOC  = 13'b0001000000000,
      S_COMMIT = 13'b0010000000000,
      S_CLEAR  = 13'b0100000000000,
      S_DONE   = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.res_status = STATUS_OK;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            case (stat.op)
               OP_GET, OP_DEL, OP_TOUT: state_in = S_DIV;
               OP_ADD: begin
                  if (stat.key_zero) begin
                     cmd.set_status = 1'b1;
                     cmd.res_status = STATUS_ZERO_KEY;
                     state_in       = S_DONE;
                  end else if (stat.key_mismatch) begin
                     cmd.set_status = 1'b1;
                     cmd.res_status = STATUS_MISMATCH;
                     state_in       = S_DONE;
                  end else begin
                     state_in = S_DIV;
                  end
               end
               OP_CLEAR: state_in = S_CLEAR;
               default:  state_in = S_DONE;
            endcase
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            cmd.head_rd = 1'b1;
            state_in    = S_INIT;
         end
         S_INIT: begin
            cmd.walk_init = 1'b1;
            state_in      = S_READ;
         end
         S_READ: begin
            if (!stat.cur_nil) begin
               cmd.node_rd = 1'b1;
               state_in    = S_CMP;
            end else begin
               state_in = S_DONE;
               case (stat.op)
                  OP_ADD: begin
                     if (stat.chain_over) begin
                        cmd.set_status = 1'b1;
                        cmd.res_status = STATUS_CHAIN;
                     end else if (stat.pool_full) begin
                        cmd.set_status = 1'b1;
                        cmd.res_status = STATUS_POOL;
                     end else begin
                        state_in = S_ALLOC;
                     end
                  end
                  OP_TOUT: begin
                     cmd.set_status = 1'b1;
                     cmd.res_status = STATUS_NOT_FOUND;
                     cmd.tout_one   = 1'b1;
                  end
                  default: begin
                     cmd.set_status = 1'b1;
                     cmd.res_status = STATUS_NOT_FOUND;
                  end
               endcase
            end
         end
         S_CMP: begin
            if (!stat.key_match) begin
               cmd.walk_adv = 1'b1;
               state_in     = S_READ;
            end else begin
               state_in = S_DONE;
               case (stat.op)
                  OP_GET: begin
                     cmd.time_wr  = 1'b1;
                     cmd.time_now = 1'b1;
                  end
                  OP_ADD: begin
                     cmd.set_status = 1'b1;
                     cmd.res_status = STATUS_DUPLICATE;
                  end
                  OP_DEL: begin
                     cmd.unlink      = 1'b1;
                     cmd.time_stored = 1'b1;
                     state_in        = S_FREE;
                  end
                  default: begin
                     cmd.time_stored = 1'b1;
                     cmd.tout_calc   = 1'b1;
                  end
               endcase
            end
         end
         S_FREE: begin
            cmd.free_push = 1'b1;
            state_in      = S_DONE;
         end
         S_ALLOC: begin
            cmd.alloc_rd = 1'b1;
            state_in     = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.alloc_commit = 1'b1;
            cmd.time_now     = 1'b1;
            state_in         = S_DONE;
         end
         S_CLEAR: begin
            cmd.clear_all = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!stat.rsp_busy) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

[rtl/cht_datapath.sv]
// ----------------------------------------------------------------------------
// cht_datapath
// Bucket heads, node pool memories, free stack, key remainder unit, result.
// ----------------------------------------------------------------------------
module cht_datapath #(
   parameter int NODES   = cht_pkg::NODES_DEFAULT,
   parameter int BUCKETS = cht_pkg::BUCKETS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  cht_pkg::req_type  req_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cht_pkg::rsp_type  rsp_data,
   input  cht_pkg::cmd_type  cmd,
   output cht_pkg::stat_type stat
);
   import cht_pkg::*;

   localparam int AW  = $clog2(NODES);
   localparam int NW  = $clog2(NODES + 1);
   localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int DCW = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
   localparam logic [NW-1:0] NIL = NW'(NODES);

   req_type         item_ff;
   logic [8:0]      bucket_count_ff;
   logic [31:0]     timeout_ff;
   logic [10:0]     chain_limit_ff;

   logic [8:0]      div_rem_ff, div_rem_in;
   logic [63:0]     div_quo_ff, div_quo_in;
   logic [DCW-1:0]  div_cnt_ff;
   logic [8:0]      div_n;
   logic [9:0]      div_r;
   logic [63:0]     div_d;

   logic [NW-1:0]   cur_ff, prev_ff, len_ff, head_val_ff;
   logic [NW-1:0]   free_top_ff, fresh_ff, used_ff;
   logic [NW-1:0]   head_eff, alloc_node;
   logic            stack_empty;
   logic [BW-1:0]   bidx;

   logic [BUCKETS-1:0] head_valid_ff;
   logic [NW-1:0]   head_mem [BUCKETS];
   logic [63:0]     key_mem  [NODES];
   logic [31:0]     time_mem [NODES];
   logic [NW-1:0]   link_mem [NODES];
   logic [NW-1:0]   head_q, link_q;
   logic [63:0]     key_q;
   logic [31:0]     time_q;

   logic            link_we;
   logic [AW-1:0]   link_waddr, link_raddr;
   logic [NW-1:0]   link_wdata;
   logic            head_we;
   logic [NW-1:0]   head_wdata;
   logic            time_we;
   logic [AW-1:0]   time_waddr;
   logic [31:0]     elapsed;

   status_type      res_status_ff;
   logic            res_tout_ff;
   logic [31:0]     res_time_ff;
   logic            rsp_valid_ff;
   rsp_type         rsp_data_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= BUCKET_COUNT_RESET;
         timeout_ff      <= TIMEOUT_RESET;
         chain_limit_ff  <= CHAIN_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BUCKET_COUNT: bucket_count_ff <= csr_wdata[8:0];
            CSR_TIMEOUT:      timeout_ff      <= csr_wdata;
            CSR_CHAIN_LIMIT:  chain_limit_ff  <= csr_wdata[10:0];
            default:          ;
         endcase
      end
   end

   // key modulo effective bucket count, restoring, DIV_BITS bits a cycle
   always_comb begin
      if (bucket_count_ff == 9'd0) begin
         div_n = 9'd1;
      end else if (32'(bucket_count_ff) > 32'(BUCKETS)) begin
         div_n = 9'(BUCKETS);
      end else begin
         div_n = bucket_count_ff;
      end
      div_r = {1'b0, div_rem_ff};
      div_d = div_quo_ff;
      for (int i = 0; i < DIV_BITS; i++) begin
         div_r = {div_r[8:0], div_d[63]};
         div_d = {div_d[62:0], 1'b0};
         if (div_r >= {1'b0, div_n}) begin
            div_r = div_r - {1'b0, div_n};
         end
      end
      div_rem_in = div_r[8:0];
      div_quo_in = div_d;
   end

   assign bidx        = BW'(div_rem_ff);
   assign stack_empty = (free_top_ff == NIL);
   assign alloc_node  = stack_empty ? fresh_ff : free_top_ff;
   assign head_eff    = head_valid_ff[bidx] ? head_q : NIL;
   assign elapsed     = item_ff.now_seconds - time_q;

   // item, remainder and walk registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff    <= req_data;
         div_rem_ff <= '0;
         div_quo_ff <= req_data.conn_key;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_rem_ff <= div_rem_in;
         div_quo_ff <= div_quo_in;
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
      if (cmd.walk_init) begin
         cur_ff      <= head_eff;
         head_val_ff <= head_eff;
         prev_ff     <= NIL;
         len_ff      <= '0;
      end else if (cmd.walk_adv) begin
         prev_ff <= cur_ff;
         cur_ff  <= link_q;
         len_ff  <= len_ff + 1'b1;
      end
   end

   // pool bookkeeping
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_all) begin
         free_top_ff   <= NIL;
         fresh_ff      <= '0;
         used_ff       <= '0;
         head_valid_ff <= '0;
      end else begin
         if (head_we) begin
            head_valid_ff[bidx] <= 1'b1;
         end
         if (cmd.free_push) begin
            free_top_ff <= cur_ff;
            if (used_ff != '0) begin
               used_ff <= used_ff - 1'b1;
            end
         end else if (cmd.alloc_commit) begin
            if (stack_empty) begin
               fresh_ff <= fresh_ff + 1'b1;
            end else begin
               free_top_ff <= link_q;
            end
            used_ff <= used_ff + 1'b1;
         end
      end
   end

   // memory write ports
   always_comb begin
      link_we    = 1'b0;
      link_waddr = cur_ff[AW-1:0];
      link_wdata = free_top_ff;
      head_we    = 1'b0;
      head_wdata = link_q;
      if (cmd.unlink) begin
         if (prev_ff != NIL) begin
            link_we    = 1'b1;
            link_waddr = prev_ff[AW-1:0];
            link_wdata = link_q;
         end else begin
            head_we = 1'b1;
         end
      end else if (cmd.free_push) begin
         link_we = 1'b1;
      end else if (cmd.alloc_commit) begin
         link_we    = 1'b1;
         link_waddr = alloc_node[AW-1:0];
         link_wdata = head_val_ff;
         head_we    = 1'b1;
         head_wdata = alloc_node;
      end
      time_we    = cmd.time_wr || cmd.alloc_commit;
      time_waddr = cmd.alloc_commit ? alloc_node[AW-1:0] : cur_ff[AW-1:0];
      link_raddr = cmd.alloc_rd ? free_top_ff[AW-1:0] : cur_ff[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[bidx] <= head_wdata;
      end
      if (cmd.head_rd) begin
         head_q <= head_mem[bidx];
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (cmd.node_rd || cmd.alloc_rd) begin
         link_q <= link_mem[link_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.alloc_commit) begin
         key_mem[alloc_node[AW-1:0]] <= item_ff.conn_key;
      end
      if (cmd.node_rd) begin
         key_q <= key_mem[cur_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (time_we) begin
         time_mem[time_waddr] <= item_ff.now_seconds;
      end
      if (cmd.node_rd) begin
         time_q <= time_mem[cur_ff[AW-1:0]];
      end
   end

   // result
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         res_status_ff <= STATUS_OK;
         res_tout_ff   <= 1'b0;
         res_time_ff   <= '0;
      end else begin
         if (cmd.set_status) begin
            res_status_ff <= cmd.res_status;
         end
         if (cmd.time_now) begin
            res_time_ff <= item_ff.now_seconds;
         end else if (cmd.time_stored) begin
            res_time_ff <= time_q;
         end
         if (cmd.tout_one) begin
            res_tout_ff <= 1'b1;
         end else if (cmd.tout_calc) begin
            res_tout_ff <= (item_ff.now_seconds >= time_q) && (elapsed > timeout_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_data_ff.status       <= res_status_ff;
         rsp_data_ff.timed_out    <= res_tout_ff;
         rsp_data_ff.entry_time   <= res_time_ff;
         rsp_data_ff.used_entries <= 11'(used_ff);
         rsp_data_ff.free_entries <= 11'(NIL - used_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign stat.op           = item_ff.operation;
   assign stat.key_zero     = (item_ff.conn_key == 64'd0);
   assign stat.key_mismatch = (item_ff.conn_key !=
                               {item_ff.owner_id, 1'b0, item_ff.sock_number});
   assign stat.div_last     = (div_cnt_ff == DCW'(DIV_STEPS - 1));
   assign stat.cur_nil      = (cur_ff == NIL);
   assign stat.key_match    = (key_q == item_ff.conn_key);
   assign stat.chain_over   = (32'(len_ff) > 32'(chain_limit_ff));
   assign stat.pool_full    = (used_ff == NIL);
   assign stat.rsp_busy     = rsp_valid_ff && !rsp_ready;

endmodule

[rtl/connection_hash_table.sv]
// ----------------------------------------------------------------------------
// connection_hash_table
// Chained hash table of connection keys over a node pool with a free list.
//
//   channel   ports                               direction
//   request   req_valid/req_ready/req_data        in
//   response  rsp_valid/rsp_ready/rsp_data        out
//   csr       csr_we/csr_index/csr_wdata          in, write only
//
// A lookup word is decoded, its key remainder is built (4 bits a cycle), the
// bucket head is read and the chain is walked, each node being read through the
// registered node memory and then compared. Add allocates a node, delete frees one.
// Reset is synchronous and sweeps no memory: head valid bits and the free pool registers clear together.
// One word is in work at a time; a finished word waits in the output register.
// ----------------------------------------------------------------------------
module connection_hash_table #(
   parameter int NODES   = cht_pkg::NODES_DEFAULT,
   parameter int BUCKETS = cht_pkg::BUCKETS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cht_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cht_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_wdata
);
   import cht_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   cht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cht_datapath #(
      .NODES   (NODES),
      .BUCKETS (BUCKETS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule
